// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the grid score store modules
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHECK_HOLDS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: check failed");
`define CHECK_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("%m: forbidden condition seen");
`else
`define CHECK_HOLDS(label, clk, rst, prop)
`define CHECK_NEVER(label, clk, rst, expr)
`endif
`endif

// ===== hw/rtl/gmss_pkg.sv =====
// shared types, codes and constants for the grid score store
// no dependencies; imported by every module of the block
package gmss_pkg;

  localparam int COORD_W    = 32;
  localparam int SCALE_W    = 32;
  localparam int SCORE_W    = 16;
  localparam int IDX_W      = 8;
  localparam int CNT_W      = 7;
  localparam int FUNC_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int Q_SHIFT    = 40;
  localparam int Q_W        = COORD_W + SCALE_W - Q_SHIFT;
  localparam int Q_DEPTH    = 2;
  localparam int SPLAT_N    = 9;
  localparam int DEF_GRID_X = 64;
  localparam int DEF_GRID_Y = 64;

  // operation codes of the request
  localparam logic [FUNC_W-1:0] FN_SET_COORD  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_SPLAT      = 3'd1;
  localparam logic [FUNC_W-1:0] FN_SET_CELL   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_READ_COORD = 3'd3;
  localparam logic [FUNC_W-1:0] FN_READ_CELL  = 3'd4;
  localparam logic [FUNC_W-1:0] FN_MAX        = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_X  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_Y  = 3'd5;

  localparam logic [COORD_W-1:0] ORIGIN_RST = '0;
  localparam logic [SCALE_W-1:0] SCALE_RST  = 32'h0100_0000;
  localparam logic [CNT_W-1:0]   CELLS_RST  = 7'd64;

  // splat neighbourhood, centre first
  localparam logic signed [1:0] NB_DX [SPLAT_N] = '{2'sd0, -2'sd1, -2'sd1, -2'sd1,
                                                    2'sd0, 2'sd0, 2'sd1, 2'sd1, 2'sd1};
  localparam logic signed [1:0] NB_DY [SPLAT_N] = '{2'sd0, 2'sd0, -2'sd1, 2'sd1,
                                                    -2'sd1, 2'sd1, -2'sd1, 2'sd0, 2'sd1};

  typedef enum logic [1:0] {
    OP_NONE,
    OP_RMW,
    OP_READ,
    OP_MAX
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t             op;
    logic                splat;
    logic [IDX_W-1:0]    col;
    logic [IDX_W-1:0]    row;
    logic [SCORE_W-1:0]  score;
  } cmd_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic [SCALE_W-1:0]        scale_x;
    logic [SCALE_W-1:0]        scale_y;
    logic [CNT_W-1:0]          lx;
    logic [CNT_W-1:0]          ly;
  } cfg_t;

endpackage

// ===== hw/rtl/gmss_front.sv =====
// request front end: maps coordinates to cells and classifies requests
// depends on gmss_pkg; feeds commands into gmss_queue
module gmss_front import gmss_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  cfg_t                      cfg,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [FUNC_W-1:0]         func,
  input  logic signed [COORD_W-1:0] pos_x,
  input  logic signed [COORD_W-1:0] pos_y,
  input  logic [IDX_W-1:0]          cell_col,
  input  logic [IDX_W-1:0]          cell_row,
  input  logic [SCORE_W-1:0]        score,
  input  logic                      clearing,
  input  logic                      full,
  output logic                      push,
  output cmd_t                      push_data
);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_SUB  = 4'b0010,
    F_MUL  = 4'b0100,
    F_PUSH = 4'b1000
  } front_state_t;

  front_state_t state;

  logic [FUNC_W-1:0]  func_q;
  logic [COORD_W-1:0] pos_x_q, pos_y_q;
  logic [IDX_W-1:0]   col_q, row_q;
  logic [SCORE_W-1:0] score_q;
  logic               neg_x, neg_y;
  logic [COORD_W-1:0] mag_x, mag_y;
  logic [Q_W-1:0]     q_x, q_y;

  logic [COORD_W:0]   dpos_x, dneg_x, dpos_y, dneg_y;
  logic [COORD_W+SCALE_W-1:0] prod_x, prod_y;
  logic               coord_op, hit_x, hit_y, hit_cell, hit, interior;
  logic [IDX_W-1:0]   cx, cy;

  assign in_stall = (state != F_IDLE) || clearing;

  // both differences in parallel, the sign picks the magnitude
  assign dpos_x = {pos_x_q[COORD_W-1], pos_x_q} - {cfg.origin_x[COORD_W-1], cfg.origin_x};
  assign dneg_x = {cfg.origin_x[COORD_W-1], cfg.origin_x} - {pos_x_q[COORD_W-1], pos_x_q};
  assign dpos_y = {pos_y_q[COORD_W-1], pos_y_q} - {cfg.origin_y[COORD_W-1], cfg.origin_y};
  assign dneg_y = {cfg.origin_y[COORD_W-1], cfg.origin_y} - {pos_y_q[COORD_W-1], pos_y_q};

  assign prod_x = mag_x * cfg.scale_x;
  assign prod_y = mag_y * cfg.scale_y;

  // negative offset truncating to zero still lands on cell zero
  assign hit_x = !(neg_x && (q_x != '0)) && (q_x < Q_W'(cfg.lx));
  assign hit_y = !(neg_y && (q_y != '0)) && (q_y < Q_W'(cfg.ly));
  assign hit_cell = (col_q < IDX_W'(cfg.lx)) && (row_q < IDX_W'(cfg.ly));

  assign coord_op = (func_q == FN_SET_COORD) || (func_q == FN_SPLAT) ||
                    (func_q == FN_READ_COORD);
  assign hit = coord_op ? (hit_x && hit_y) : hit_cell;
  assign cx  = coord_op ? q_x[IDX_W-1:0] : col_q;
  assign cy  = coord_op ? q_y[IDX_W-1:0] : row_q;

  assign interior = (cx != '0) && ((IDX_W+1)'(cx) + (IDX_W+1)'(1) < (IDX_W+1)'(cfg.lx)) &&
                    (cy != '0) && ((IDX_W+1)'(cy) + (IDX_W+1)'(1) < (IDX_W+1)'(cfg.ly));

  always_comb begin
    push_data.op    = OP_NONE;
    push_data.splat = 1'b0;
    push_data.col   = cx;
    push_data.row   = cy;
    push_data.score = score_q;
    unique case (func_q) inside
      FN_SET_COORD, FN_SET_CELL: begin
        if (hit) push_data.op = OP_RMW;
      end
      FN_SPLAT: begin
        if (hit) begin
          push_data.op    = OP_RMW;
          push_data.splat = interior;
        end
      end
      FN_READ_COORD, FN_READ_CELL: begin
        if (hit) push_data.op = OP_READ;
      end
      FN_MAX: begin
        if ((cfg.lx != '0) && (cfg.ly != '0)) push_data.op = OP_MAX;
      end
      default: begin
        push_data.op = OP_NONE;
      end
    endcase
  end

  assign push = (state == F_PUSH) && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (in_valid && !clearing) begin
            func_q  <= func;
            pos_x_q <= pos_x;
            pos_y_q <= pos_y;
            col_q   <= cell_col;
            row_q   <= cell_row;
            score_q <= score;
            state   <= F_SUB;
          end
        end
        F_SUB: begin
          neg_x <= dpos_x[COORD_W];
          neg_y <= dpos_y[COORD_W];
          mag_x <= dpos_x[COORD_W] ? dneg_x[COORD_W-1:0] : dpos_x[COORD_W-1:0];
          mag_y <= dpos_y[COORD_W] ? dneg_y[COORD_W-1:0] : dpos_y[COORD_W-1:0];
          state <= F_MUL;
        end
        F_MUL: begin
          q_x   <= prod_x[COORD_W+SCALE_W-1:Q_SHIFT];
          q_y   <= prod_y[COORD_W+SCALE_W-1:Q_SHIFT];
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (!full) state <= F_IDLE;
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/gmss_queue.sv =====
// short command queue between front end and store back end
// depends on gmss_pkg and assert_macros.svh
`include "assert_macros.svh"
module gmss_queue import gmss_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic empty
);

  localparam int PW = $clog2(Q_DEPTH);
  localparam int CW = $clog2(Q_DEPTH + 1);

  cmd_t          slots [Q_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full     = (count == CW'(Q_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) wr_ptr <= (wr_ptr == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (pop && !empty) rd_ptr <= (rd_ptr == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if ((push && !full) && !(pop && !empty)) count <= count + CW'(1);
      else if (!(push && !full) && (pop && !empty)) count <= count - CW'(1);
    end
  end

  `CHECK_NEVER(a_pop_when_empty, clk, rst, pop && empty)
  `CHECK_NEVER(a_push_when_full, clk, rst, push && full)
  `CHECK_HOLDS(a_count_bound, clk, rst, count <= CW'(Q_DEPTH))

endmodule

// ===== hw/rtl/gmss_back.sv =====
// store back end: score memory, read-modify-write walker, max scan, result register
// depends on gmss_pkg and assert_macros.svh; takes commands from gmss_queue
`include "assert_macros.svh"
module gmss_back import gmss_pkg::*; #(
  parameter int GRID_X = DEF_GRID_X,
  parameter int GRID_Y = DEF_GRID_Y
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               empty,
  input  cmd_t               pop_data,
  output logic               pop,
  output logic               clearing,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [SCORE_W-1:0] entry,
  output logic               in_range
);

  localparam int DEPTH = GRID_X * GRID_Y;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(SPLAT_N);

  typedef enum logic [4:0] {
    B_CLEAR = 5'b00001,
    B_IDLE  = 5'b00010,
    B_RUN   = 5'b00100,
    B_DRAIN = 5'b01000,
    B_DONE  = 5'b10000
  } back_state_t;

  back_state_t state;

  logic [SCORE_W-1:0] mem [DEPTH];
  logic [SCORE_W-1:0] rdata;

  cmd_t               cmd;
  logic [SW-1:0]      step;
  logic [CNT_W-1:0]   sc, sr;
  logic [AW-1:0]      rb, prev_addr, clr;
  logic               pend;
  logic [SCORE_W-1:0] acc;

  logic [IDX_W:0]     nx, ny;
  logic [AW-1:0]      nb_addr, scan_addr, rd_addr, mem_waddr;
  logic [SCORE_W-1:0] mem_wdata;
  logic               mem_we, mem_re;
  logic               nb_last, col_last, row_last, run_last, out_free;

  assign nx = {1'b0, cmd.col} + {{(IDX_W-1){NB_DX[step][1]}}, NB_DX[step]};
  assign ny = {1'b0, cmd.row} + {{(IDX_W-1){NB_DY[step][1]}}, NB_DY[step]};
  assign nb_addr   = AW'(ny) * AW'(GRID_X) + AW'(nx);
  assign scan_addr = rb + AW'(sc);
  assign rd_addr   = (cmd.op == OP_MAX) ? scan_addr : nb_addr;

  assign nb_last  = (cmd.op == OP_RMW && cmd.splat) ? (step == SW'(SPLAT_N - 1)) : 1'b1;
  assign col_last = (sc == cfg.lx - CNT_W'(1));
  assign row_last = (sr == cfg.ly - CNT_W'(1));
  assign run_last = (cmd.op == OP_MAX) ? (col_last && row_last) : nb_last;

  // read of one cell overlaps the write-back of the one before it
  assign mem_re    = (state == B_RUN);
  assign mem_we    = (state == B_CLEAR) || (pend && cmd.op == OP_RMW && rdata <= cmd.score);
  assign mem_waddr = (state == B_CLEAR) ? clr : prev_addr;
  assign mem_wdata = (state == B_CLEAR) ? '0 : cmd.score;

  assign out_free = !out_valid || !out_stall;
  assign pop      = (state == B_IDLE) && !empty;
  assign clearing = (state == B_CLEAR);

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      clr       <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // a new result in the done state takes over the slot itself
      if (out_valid && !out_stall && state != B_DONE) out_valid <= 1'b0;
      unique case (state)
        B_CLEAR: begin
          clr <= clr + AW'(1);
          if (clr == AW'(DEPTH - 1)) state <= B_IDLE;
        end
        B_IDLE: begin
          if (!empty) begin
            cmd   <= pop_data;
            step  <= '0;
            sc    <= '0;
            sr    <= '0;
            rb    <= '0;
            acc   <= '0;
            state <= (pop_data.op == OP_NONE) ? B_DONE : B_RUN;
          end
        end
        B_RUN: begin
          pend      <= 1'b1;
          prev_addr <= rd_addr;
          if (cmd.op == OP_MAX) begin
            if (col_last) begin
              sc <= '0;
              sr <= sr + CNT_W'(1);
              rb <= rb + AW'(GRID_X);
            end else begin
              sc <= sc + CNT_W'(1);
            end
          end else begin
            step <= step + SW'(1);
          end
          if (run_last) state <= B_DRAIN;
        end
        B_DRAIN: begin
          pend  <= 1'b0;
          state <= B_DONE;
        end
        B_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            entry     <= (cmd.op == OP_READ || cmd.op == OP_MAX) ? acc : '0;
            in_range  <= (cmd.op != OP_NONE);
            state     <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
      if (pend) begin
        if (cmd.op == OP_READ) acc <= rdata;
        else if (cmd.op == OP_MAX && rdata > acc) acc <= rdata;
      end
    end
  end

  `CHECK_HOLDS(a_result_from_done, clk, rst, $rose(out_valid) |-> $past(state == B_DONE))
  `CHECK_HOLDS(a_write_owner, clk, rst,
    mem_we |-> (state == B_CLEAR || ((state == B_RUN || state == B_DRAIN) && cmd.op == OP_RMW)))
  `CHECK_HOLDS(a_out_hold, clk, rst,
    (out_valid && out_stall) |=> (out_valid && $stable(entry) && $stable(in_range)))

endmodule

// ===== hw/rtl/grid_max_splat_store.sv =====
// Grid score store top level: configuration registers, front end, command queue, back end.
// depends on gmss_pkg, gmss_front, gmss_queue and gmss_back
//
// A request passes the front end through capture, origin subtract, scale multiply and
// classify, and then waits in a two-entry command queue for the back end, which owns the
// score memory with its separate read and write ports. In the back end a splat whose
// centre is strictly inside the active grid makes nine pipelined read-modify-write
// updates, a max scan reads all cells_x*cells_y active cells, and an out-of-range or
// unused request skips the memory. The memory port sets the throughput: front and back
// overlap, so the back end paces a run of splats. After reset it clears all GRID_X*GRID_Y
// cells, one per cycle, and in_stall stays high during that pass; configuration writes
// are taken at any time but must only be issued while the block is idle.
module grid_max_splat_store import gmss_pkg::*; #(
  parameter int GRID_X = DEF_GRID_X,
  parameter int GRID_Y = DEF_GRID_Y
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [FUNC_W-1:0]         func,
  input  logic signed [COORD_W-1:0] pos_x,
  input  logic signed [COORD_W-1:0] pos_y,
  input  logic [IDX_W-1:0]          cell_col,
  input  logic [IDX_W-1:0]          cell_row,
  input  logic [SCORE_W-1:0]        score,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [SCORE_W-1:0]        entry,
  output logic                      in_range
);

  logic [COORD_W-1:0] origin_x, origin_y;
  logic [SCALE_W-1:0] scale_x, scale_y;
  logic [CNT_W-1:0]   cells_x, cells_y;

  cfg_t cfg;
  cmd_t push_data, pop_data;
  logic push, pop, full, empty, clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= ORIGIN_RST;
      origin_y <= ORIGIN_RST;
      scale_x  <= SCALE_RST;
      scale_y  <= SCALE_RST;
      cells_x  <= CELLS_RST;
      cells_y  <= CELLS_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ORIGIN_X: origin_x <= cfg_data[COORD_W-1:0];
        REG_ORIGIN_Y: origin_y <= cfg_data[COORD_W-1:0];
        REG_SCALE_X:  scale_x  <= cfg_data[SCALE_W-1:0];
        REG_SCALE_Y:  scale_y  <= cfg_data[SCALE_W-1:0];
        REG_CELLS_X:  cells_x  <= cfg_data[CNT_W-1:0];
        REG_CELLS_Y:  cells_y  <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // active counts are clamped to the built grid
  always_comb begin
    cfg.origin_x = origin_x;
    cfg.origin_y = origin_y;
    cfg.scale_x  = scale_x;
    cfg.scale_y  = scale_y;
    cfg.lx = ((IDX_W+1)'(cells_x) > (IDX_W+1)'(GRID_X)) ? CNT_W'(GRID_X) : cells_x;
    cfg.ly = ((IDX_W+1)'(cells_y) > (IDX_W+1)'(GRID_Y)) ? CNT_W'(GRID_Y) : cells_y;
  end

  gmss_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .cell_col  (cell_col),
    .cell_row  (cell_row),
    .score     (score),
    .clearing  (clearing),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  gmss_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  gmss_back #(
    .GRID_X (GRID_X),
    .GRID_Y (GRID_Y)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .empty     (empty),
    .pop_data  (pop_data),
    .pop       (pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .entry     (entry),
    .in_range  (in_range)
  );

endmodule
